FILE: rtl/core/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation pipeline.
// Used by bsc_udiv and barometric_sensor_compensation_unit; depends on nothing.
package bsc_pkg;

  localparam int DIV_STEPS = 32;
  localparam int SIDE_W    = 64;

  localparam logic [31:0] T_OFFSET = 32'd4000;
  localparam logic [31:0] P_BIAS   = 32'd32768;
  localparam logic [31:0] P_SCALE  = 32'd50000;
  localparam logic [31:0] C_SQ     = 32'd3038;
  localparam logic [31:0] C_LIN    = 32'hFFFF_E343;
  localparam logic [31:0] C_ROUND  = 32'd3791;
  localparam logic [31:0] T_ROUND  = 32'd8;

  typedef enum logic [2:0] {
    REG_AC12 = 3'd0,
    REG_AC34 = 3'd1,
    REG_AC56 = 3'd2,
    REG_B12  = 3'd3,
    REG_MCMD = 3'd4,
    REG_OSS  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic div_t div_step(input div_t s, input logic [31:0] d);
    logic [32:0] t;
    logic [33:0] diff;
    div_t r;
    t = {s.rem, s.quo[31]};
    diff = {1'b0, t} - {2'b00, d};
    r.quo = {s.quo[30:0], ~diff[33]};
    r.rem = diff[33] ? t[31:0] : diff[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/bsc_udiv.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Carries a sideband word alongside each item; depends on bsc_pkg.
module bsc_udiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [31:0]                 dividend,
  input  logic [31:0]                 divisor,
  input  logic [bsc_pkg::SIDE_W-1:0]  side_in,
  output logic                        out_valid,
  output logic [31:0]                 quotient,
  output logic [bsc_pkg::SIDE_W-1:0]  side_out
);

  bsc_pkg::div_t               st [0:bsc_pkg::DIV_STEPS-1];
  logic [31:0]                 dv [0:bsc_pkg::DIV_STEPS-1];
  logic [bsc_pkg::SIDE_W-1:0]  sd [0:bsc_pkg::DIV_STEPS-1];
  logic [bsc_pkg::DIV_STEPS-1:0] vl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (en) begin
      vl <= {vl[bsc_pkg::DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= bsc_pkg::div_step({32'd0, dividend}, divisor);
      dv[0] <= divisor;
      sd[0] <= side_in;
      for (int k = 1; k < bsc_pkg::DIV_STEPS; k++) begin
        st[k] <= bsc_pkg::div_step(st[k-1], dv[k-1]);
        dv[k] <= dv[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = vl[bsc_pkg::DIV_STEPS-1];
  assign quotient  = st[bsc_pkg::DIV_STEPS-1].quo;
  assign side_out  = sd[bsc_pkg::DIV_STEPS-1];

endmodule

FILE: rtl/core/barometric_sensor_compensation_unit.sv
// Barometric temperature/pressure compensation, top level; depends on bsc_pkg, bsc_udiv.
// Throughput one item per cycle while the output register is empty or taken.
// The pipeline is made of the two 32-stage dividers plus 13 arithmetic stages.
// The whole pipeline advances together while the output register is empty or taken.
// Synchronous reset clears all valid bits and sets every calibration register to zero.
module barometric_sensor_compensation_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  raw_temperature,
  input  logic [18:0]  raw_pressure,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  temperature,
  output logic [31:0]  pressure,
  output logic         divide_error,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0] ac12, ac34, ac56, b12, mcmd;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac12 <= '0;
      ac34 <= '0;
      ac56 <= '0;
      b12  <= '0;
      mcmd <= '0;
      oss  <= '0;
    end else if (cfg_we) begin
      case (bsc_pkg::reg_idx_t'(cfg_index))
        bsc_pkg::REG_AC12: ac12 <= cfg_data;
        bsc_pkg::REG_AC34: ac34 <= cfg_data;
        bsc_pkg::REG_AC56: ac56 <= cfg_data;
        bsc_pkg::REG_B12:  b12  <= cfg_data;
        bsc_pkg::REG_MCMD: mcmd <= cfg_data;
        bsc_pkg::REG_OSS:  oss  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bsc_pkg::sx16(ac12[31:16]);
  assign ac2 = bsc_pkg::sx16(ac12[15:0]);
  assign ac3 = bsc_pkg::sx16(ac34[31:16]);
  assign ac4 = {16'd0, ac34[15:0]};
  assign ac5 = {16'd0, ac56[31:16]};
  assign ac6 = {16'd0, ac56[15:0]};
  assign b1  = bsc_pkg::sx16(b12[31:16]);
  assign b2  = bsc_pkg::sx16(b12[15:0]);
  assign mc  = bsc_pkg::sx16(mcmd[31:16]);
  assign md  = bsc_pkg::sx16(mcmd[15:0]);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v11, v12, v13, v14;

  // stage 1..2: temperature raw product and signed divide setup
  logic [31:0] m1;
  logic [18:0] up1, up2, up3, up4, up5, up6, up7;
  logic [31:0] x1_2, dn2, dd2;
  logic        sgn2, err2;
  logic [31:0] x1c, den, num;

  assign x1c = bsc_pkg::asr(m1, 15);
  assign den = x1c + md;
  assign num = mc << 11;

  always_ff @(posedge clk) begin
    if (en) begin
      up1  <= raw_pressure;
      m1   <= 32'(({16'd0, raw_temperature} - ac6) * ac5);
      up2  <= up1;
      x1_2 <= x1c;
      dn2  <= num[31] ? 32'(-num) : num;
      dd2  <= den[31] ? 32'(-den) : den;
      sgn2 <= num[31] ^ den[31];
      err2 <= (den == 32'd0);
    end
  end

  logic                       vt;
  logic [31:0]                qt;
  logic [bsc_pkg::SIDE_W-1:0] st_in, st_out;
  assign st_in = {11'd0, err2, sgn2, up2, x1_2};

  bsc_udiv u_tdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .dividend(dn2), .divisor(dd2), .side_in(st_in),
    .out_valid(vt), .quotient(qt), .side_out(st_out)
  );

  // stages 3..9: B5 through B7
  logic [31:0] qs, b5;
  assign qs = st_out[51] ? 32'(-qt) : qt;
  assign b5 = st_out[31:0] + qs;

  logic [31:0] t3, t4, t5, t6, t7, t8, t9;
  logic [31:0] b6_3, sqp4, a2p4, a3p4, sq5, x2a5, x1b5, b2p6, b1p6, x2a6, x1b6;
  logic [31:0] b3_7, v7b, b4p8, diff8, b4_9, b7_9;
  logic        err3, err4, err5, err6, err7, err8, err9;
  logic [31:0] x3_7, b3c, x3b;

  assign x3_7 = bsc_pkg::asr(b2p6, 11) + x2a6;
  assign b3c  = bsc_pkg::asr(32'(((ac1 << 2) + x3_7) << oss) + 32'd2, 2);
  assign x3b  = bsc_pkg::asr(x1b6 + bsc_pkg::asr(b1p6, 16) + 32'd2, 2);

  always_ff @(posedge clk) begin
    if (en) begin
      t3   <= bsc_pkg::asr(b5 + bsc_pkg::T_ROUND, 4);
      b6_3 <= b5 - bsc_pkg::T_OFFSET;
      up3  <= st_out[50:32];
      err3 <= st_out[52];

      sqp4 <= 32'(b6_3 * b6_3);
      a2p4 <= 32'(ac2 * b6_3);
      a3p4 <= 32'(ac3 * b6_3);
      t4 <= t3; up4 <= up3; err4 <= err3;

      sq5  <= bsc_pkg::asr(sqp4, 12);
      x2a5 <= bsc_pkg::asr(a2p4, 11);
      x1b5 <= bsc_pkg::asr(a3p4, 13);
      t5 <= t4; up5 <= up4; err5 <= err4;

      b2p6 <= 32'(b2 * sq5);
      b1p6 <= 32'(b1 * sq5);
      x2a6 <= x2a5;
      x1b6 <= x1b5;
      t6 <= t5; up6 <= up5; err6 <= err5;

      b3_7 <= b3c;
      v7b  <= x3b + bsc_pkg::P_BIAS;
      t7 <= t6; up7 <= up6; err7 <= err6;

      b4p8  <= 32'(ac4 * v7b);
      diff8 <= {13'd0, up7} - b3_7;
      t8 <= t7; err8 <= err7;

      b4_9  <= {15'd0, b4p8[31:15]};
      b7_9  <= 32'(diff8 * (bsc_pkg::P_SCALE >> oss));
      err9  <= err8 | (b4p8[31:15] == 17'd0);
      t9 <= t8;
    end
  end

  logic                       vp;
  logic [31:0]                qp, dvd9;
  logic [bsc_pkg::SIDE_W-1:0] sp_in, sp_out;
  assign dvd9  = b7_9[31] ? b7_9 : (b7_9 << 1);
  assign sp_in = {30'd0, b7_9[31], err9, t9};

  bsc_udiv u_pdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(v9),
    .dividend(dvd9), .divisor(b4_9), .side_in(sp_in),
    .out_valid(vp), .quotient(qp), .side_out(sp_out)
  );

  // stages 11..14: polynomial correction and output register
  logic [31:0] p11, p12, p13, t11, t12, t13, ps, sqp12, m2_12, m3_13, x2_13, pfin;
  logic        err11, err12, err13;

  assign ps   = bsc_pkg::asr(p11, 8);
  assign pfin = p13 + bsc_pkg::asr(bsc_pkg::asr(m3_13, 16) + x2_13 + bsc_pkg::C_ROUND, 4);

  always_ff @(posedge clk) begin
    if (en) begin
      p11   <= sp_out[33] ? (qp << 1) : qp;
      t11   <= sp_out[31:0];
      err11 <= sp_out[32];

      sqp12 <= 32'(ps * ps);
      m2_12 <= 32'(p11 * bsc_pkg::C_LIN);
      p12 <= p11; t12 <= t11; err12 <= err11;

      m3_13 <= 32'(sqp12 * bsc_pkg::C_SQ);
      x2_13 <= bsc_pkg::asr(m2_12, 16);
      p13 <= p12; t13 <= t12; err13 <= err12;

      temperature  <= err13 ? 32'd0 : t13;
      pressure     <= err13 ? 32'd0 : pfin;
      divide_error <= err13;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v11, v12, v13, v14} <= '0;
    end else if (en) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= vt;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v11 <= vp;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
    end
  end

  assign out_valid = v14;

  logic [12:0] vvec;
  assign vvec = {v1, v2, v3, v4, v5, v6, v7, v8, v9, v11, v12, v13, v14};

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_error) |-> (temperature == 32'd0 && pressure == 32'd0))
    else $error("error item carries nonzero results");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vvec))
    else $error("pipeline valid bits moved during stall");

  a_reset: assert property (@(posedge clk)
    rst |=> (vvec == 13'd0))
    else $error("valid bits not cleared by reset");

endmodule
